### design/all_pairs_shortest_path_defines.svh
// Assertion macros shared by the shortest path block.
// Each macro checks a property on the rising clock edge, outside of reset.
`ifndef ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge.
`define APSP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("apsp assertion failed");

// The condition must never be true.
`define APSP_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("apsp forbidden condition seen");

`else

`define APSP_ASSERT(name, clk, rst_n, prop)
`define APSP_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

### design/apsp_pkg.sv
package apsp_pkg;

  // Field widths of the interface words.
  localparam int unsigned WEIGHT_W    = 20;
  localparam int unsigned VIA_W       = 4;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned VCOUNT_W    = 4;
  localparam int unsigned ADDR_FULL_W = 6;

  // A weight of this value marks a missing edge.
  localparam logic [WEIGHT_W-1:0] NO_EDGE = 20'd999999;

  // Vertex count after reset.
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 4'd4;

  // Operations that the controller issues to the datapath.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_PIVOT = 3'd2,
    OP_RELAX = 3'd3,
    OP_EMIT  = 3'd4
  } op_e;

  // Command from controller to datapath.
  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] k;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] n_last;
    logic             last;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_valid;
    logic out_free;
  } status_t;

  // Matrix entry address, row-major with a row length of n_last + 1.
  function automatic logic [ADDR_FULL_W-1:0] vertex_addr(input logic [IDX_W-1:0] row,
                                                         input logic [IDX_W-1:0] col,
                                                         input logic [IDX_W-1:0] n_last);
    logic [ADDR_FULL_W-1:0] prod;
    prod = ADDR_FULL_W'(row) * ADDR_FULL_W'(n_last);
    return prod + ADDR_FULL_W'(row) + ADDR_FULL_W'(col);
  endfunction

endpackage

### design/apsp_ram.sv
module apsp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### design/apsp_ctrl.sv
`include "all_pairs_shortest_path_defines.svh"

module apsp_ctrl #(
  parameter int unsigned MAX_VERTICES = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [apsp_pkg::VCOUNT_W-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  apsp_pkg::status_t                  status_i,
  output apsp_pkg::cmd_t                     cmd_o
);

  localparam int unsigned IW = apsp_pkg::IDX_W;

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_PIVOT = 5'b00010,
    S_ROW   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e                          state_q, state_d;
  logic [apsp_pkg::VCOUNT_W-1:0]   vcount_q, vcount_d;
  logic [IW-1:0]                   k_q, k_d;
  logic [IW-1:0]                   i_q, i_d;
  logic [IW-1:0]                   j_q, j_d;
  logic                            pend_q, pend_d;
  logic [IW-1:0]                   n_last;
  logic                            at_last;

  // Active vertex count minus one, with zero read as one and large counts saturated.
  always_comb begin
    if (vcount_q == '0) begin
      n_last = '0;
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      n_last = IW'(MAX_VERTICES - 1);
    end else begin
      n_last = IW'(vcount_q - 1'b1);
    end
  end

  assign at_last = (i_q == n_last) && (j_q == n_last);

  // Sequencer: load, relax over every pivot, then read out.
  always_comb begin
    state_d    = state_q;
    vcount_d   = vcount_q;
    k_d        = k_q;
    i_d        = i_q;
    j_d        = j_q;
    pend_d     = 1'b0;
    in_ready_o = 1'b0;
    cmd_o.op     = apsp_pkg::OP_NONE;
    cmd_o.k      = k_q;
    cmd_o.i      = i_q;
    cmd_o.j      = j_q;
    cmd_o.n_last = n_last;
    cmd_o.last   = at_last;

    if (cfg_we_i) begin
      vcount_d = cfg_wdata_i;
    end

    case (state_q)
      S_LOAD: begin
        // A register write takes the cycle, so no weight is taken beside it.
        in_ready_o = !cfg_we_i;
        if (cfg_we_i) begin
          i_d = '0;
          j_d = '0;
        end else if (in_valid_i) begin
          cmd_o.op = apsp_pkg::OP_LOAD;
          if (at_last) begin
            i_d     = '0;
            j_d     = '0;
            k_d     = '0;
            state_d = S_PIVOT;
          end else if (j_q == n_last) begin
            j_d = '0;
            i_d = i_q + 1'b1;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      S_PIVOT: begin
        cmd_o.op = apsp_pkg::OP_PIVOT;
        j_d      = '0;
        state_d  = S_ROW;
      end
      S_ROW: begin
        cmd_o.op = apsp_pkg::OP_RELAX;
        if (j_q == n_last) begin
          j_d = '0;
          if (i_q == n_last) begin
            i_d = '0;
            if (k_q == n_last) begin
              k_d     = '0;
              state_d = S_DRAIN;
            end else begin
              k_d     = k_q + 1'b1;
              state_d = S_PIVOT;
            end
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_PIVOT;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_DRAIN: begin
        // The last relaxation write lands in this cycle.
        i_d     = '0;
        j_d     = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!pend_q && status_i.out_free) begin
          cmd_o.op = apsp_pkg::OP_EMIT;
          pend_d   = 1'b1;
          if (at_last) begin
            i_d     = '0;
            j_d     = '0;
            state_d = S_LOAD;
          end else if (j_q == n_last) begin
            j_d = '0;
            i_d = i_q + 1'b1;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      vcount_q <= apsp_pkg::VCOUNT_RESET;
      k_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      vcount_q <= vcount_d;
      k_q      <= k_d;
      i_q      <= i_d;
      j_q      <= j_d;
      pend_q   <= pend_d;
    end
  end

  // Read-out requests never go out back to back.
  `APSP_ASSERT(a_emit_spaced, clk_i, rst_ni,
               cmd_o.op == apsp_pkg::OP_EMIT |=> cmd_o.op != apsp_pkg::OP_EMIT)
  // The drain cycle always hands over to read-out.
  `APSP_ASSERT(a_drain_to_emit, clk_i, rst_ni, state_q == S_DRAIN |=> state_q == S_EMIT)
  // A register write while loading restarts the matrix.
  `APSP_ASSERT(a_cfg_restart, clk_i, rst_ni,
               (cfg_we_i && state_q == S_LOAD) |=> (i_q == '0 && j_q == '0))

endmodule

### design/apsp_datapath.sv
`include "all_pairs_shortest_path_defines.svh"

module apsp_datapath #(
  parameter int unsigned MAX_VERTICES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  apsp_pkg::cmd_t                cmd_i,
  output apsp_pkg::status_t             status_o,
  input  logic [apsp_pkg::WEIGHT_W-1:0] edge_weight_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [apsp_pkg::IDX_W-1:0]    row_vertex_o,
  output logic [apsp_pkg::IDX_W-1:0]    col_vertex_o,
  output logic [apsp_pkg::WEIGHT_W-1:0] distance_o,
  output logic [apsp_pkg::VIA_W-1:0]    via_vertex_o,
  output logic                          last_of_run_o
);

  localparam int unsigned DEPTH  = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WW     = apsp_pkg::WEIGHT_W;
  localparam int unsigned VW     = apsp_pkg::VIA_W;
  localparam int unsigned IW     = apsp_pkg::IDX_W;
  localparam int unsigned WORD_W = WW + VW;

  logic [apsp_pkg::ADDR_FULL_W-1:0] addr_ij, addr_ik, addr_kj;
  logic [AW-1:0]                    raddr_a;
  logic                             we;
  logic [AW-1:0]                    waddr;
  logic [WORD_W-1:0]                wdata;
  logic [WORD_W-1:0]                rdata_a, rdata_b;
  logic [WW-1:0]                    weight_sat;
  logic [WW:0]                      cand;
  logic                             improve;

  apsp_pkg::op_e                    op_q;
  logic [IW-1:0]                    st_k_q, st_i_q, st_j_q;
  logic                             st_last_q;
  logic [AW-1:0]                    st_addr_q;
  logic [WW-1:0]                    pivot_q;

  logic                             out_valid_q;
  logic [IW-1:0]                    row_q, col_q;
  logic [WW-1:0]                    dist_q;
  logic [VW-1:0]                    via_q;
  logic                             last_q;

  // Addresses of the three entries one relaxation step touches.
  assign addr_ij = apsp_pkg::vertex_addr(cmd_i.i, cmd_i.j, cmd_i.n_last);
  assign addr_ik = apsp_pkg::vertex_addr(cmd_i.i, cmd_i.k, cmd_i.n_last);
  assign addr_kj = apsp_pkg::vertex_addr(cmd_i.k, cmd_i.j, cmd_i.n_last);

  always_comb begin
    case (cmd_i.op)
      apsp_pkg::OP_PIVOT: raddr_a = addr_ik[AW-1:0];
      apsp_pkg::OP_RELAX: raddr_a = addr_kj[AW-1:0];
      default:            raddr_a = addr_ij[AW-1:0];
    endcase
  end

  // Incoming weights above the no-edge mark are clipped to it.
  assign weight_sat = (edge_weight_i > apsp_pkg::NO_EDGE) ? apsp_pkg::NO_EDGE : edge_weight_i;

  // Candidate path through the pivot, one bit wider so it cannot wrap.
  assign cand    = {1'b0, pivot_q} + {1'b0, rdata_a[WW-1:0]};
  assign improve = cand < {1'b0, rdata_b[WW-1:0]};

  // Write port: a loaded weight clears its via field; a relaxation writes the shorter path.
  always_comb begin
    we    = 1'b0;
    waddr = addr_ij[AW-1:0];
    wdata = {{VW{1'b0}}, weight_sat};
    if (cmd_i.op == apsp_pkg::OP_LOAD) begin
      we = 1'b1;
    end else if (op_q == apsp_pkg::OP_RELAX && improve) begin
      we    = 1'b1;
      waddr = st_addr_q;
      wdata = {VW'({1'b0, st_k_q}) + VW'(1), cand[WW-1:0]};
    end
  end

  apsp_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .raddr_b_i(addr_ij[AW-1:0]),
    .rdata_b_o(rdata_b)
  );

  // Stage that lines the command up with the registered read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= apsp_pkg::OP_NONE;
    end else begin
      op_q <= cmd_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    st_k_q    <= cmd_i.k;
    st_i_q    <= cmd_i.i;
    st_j_q    <= cmd_i.j;
    st_last_q <= cmd_i.last;
    st_addr_q <= addr_ij[AW-1:0];
    if (op_q == apsp_pkg::OP_PIVOT) begin
      pivot_q <= rdata_a[WW-1:0];
    end
  end

  // Output word register, held until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_q == apsp_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_q == apsp_pkg::OP_EMIT) begin
      row_q  <= st_i_q;
      col_q  <= st_j_q;
      dist_q <= rdata_a[WW-1:0];
      via_q  <= rdata_a[WORD_W-1:WW];
      last_q <= st_last_q;
    end
  end

  assign status_o.out_valid = out_valid_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign row_vertex_o  = row_q;
  assign col_vertex_o  = col_q;
  assign distance_o    = dist_q;
  assign via_vertex_o  = via_q;
  assign last_of_run_o = last_q;

  // A waiting word is never overwritten by the next read-out.
  `APSP_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
                     out_valid_q && !out_ready_i && op_q == apsp_pkg::OP_EMIT)
  // Every pivot fetch is followed by a relaxation step of that row.
  `APSP_ASSERT(a_pivot_then_relax, clk_i, rst_ni,
               op_q == apsp_pkg::OP_PIVOT |=> op_q == apsp_pkg::OP_RELAX)
  // Loading and relaxation never compete for the write port.
  `APSP_ASSERT_NEVER(a_write_port_free, clk_i, rst_ni,
                     cmd_i.op == apsp_pkg::OP_LOAD && op_q == apsp_pkg::OP_RELAX)

endmodule

### design/all_pairs_shortest_path.sv
// All-pairs shortest path engine (Floyd-Warshall).
// Set the vertex count n with cfg_we_i/cfg_wdata_i while the block is idle; a write
// also restarts the matrix being loaded. A value of 0 counts as 1, and values above
// MAX_VERTICES saturate.
// The input channel (in_valid_i/in_ready_o) takes one edge weight per word, row-major,
// n*n words per matrix; 999999 means no edge and larger values are clipped to it.
// After the last weight the block relaxes every entry over every pivot vertex. One
// shared two-read-port store does one step per cycle, plus one pivot fetch per row,
// and a drain state follows. in_ready_o is low meanwhile.
// Results leave on out_valid_o/out_ready_i, n*n words row-major, last_of_run_o marking
// the final one. Each word passes a store read, then the output register, and read-out
// requests are never issued back to back.
// A stalled receiver holds the output register; read-out simply pauses. Loading of the
// next matrix starts once the last result is read from the store, while that result
// may still wait in the output register.
// Reset sets the vertex count to 4 and clears the load position; the store contents
// are not cleared, since every entry is rewritten by each load.
module all_pairs_shortest_path #(
  parameter int unsigned MAX_VERTICES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [apsp_pkg::VCOUNT_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [apsp_pkg::WEIGHT_W-1:0] edge_weight_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [apsp_pkg::IDX_W-1:0]    row_vertex_o,
  output logic [apsp_pkg::IDX_W-1:0]    col_vertex_o,
  output logic [apsp_pkg::WEIGHT_W-1:0] distance_o,
  output logic [apsp_pkg::VIA_W-1:0]    via_vertex_o,
  output logic                          last_of_run_o
);

  apsp_pkg::cmd_t    cmd;
  apsp_pkg::status_t status;

  // Sequencer.
  apsp_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Distance store, relaxation unit and output register.
  apsp_datapath #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .edge_weight_i(edge_weight_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .row_vertex_o (row_vertex_o),
    .col_vertex_o (col_vertex_o),
    .distance_o   (distance_o),
    .via_vertex_o (via_vertex_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

### sim/apsp_checker.sv
// Watches the configuration port and both word channels of the shortest path
// block, keeps its own copy of the matrix and works out the distances that each
// completed load must produce, then checks every result word in order.
module apsp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [apsp_pkg::VCOUNT_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [apsp_pkg::WEIGHT_W-1:0] edge_weight_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [apsp_pkg::IDX_W-1:0]    row_vertex_i,
  input  logic [apsp_pkg::IDX_W-1:0]    col_vertex_i,
  input  logic [apsp_pkg::WEIGHT_W-1:0] distance_i,
  input  logic [apsp_pkg::VIA_W-1:0]    via_vertex_i,
  input  logic                          last_of_run_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_N = 8;
  localparam int unsigned WW    = apsp_pkg::WEIGHT_W;
  localparam int unsigned VW    = apsp_pkg::VIA_W;
  localparam int unsigned IW    = apsp_pkg::IDX_W;
  localparam int unsigned CW    = apsp_pkg::VCOUNT_W;

  typedef struct packed {
    logic [IW-1:0] row;
    logic [IW-1:0] col;
    logic [WW-1:0] path_len;
    logic [VW-1:0] via;
    logic          last;
  } path_entry_t;

  logic [CW-1:0] vertex_count;
  logic [WW-1:0] dist_mem [MAX_N*MAX_N];
  logic [VW-1:0] via_mem [MAX_N*MAX_N];
  int unsigned   fill_pos;
  int unsigned   mismatches;
  path_entry_t   due_paths [$];

  // A count of zero means one vertex, and counts above the maximum saturate.
  function automatic int unsigned live_vertices(input logic [CW-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_N) return MAX_N;
    return 32'(v);
  endfunction

  // Relax every entry over every intermediate vertex, then queue the whole
  // matrix in row-major order. Sums are formed one bit wider so that a path
  // through a missing edge can never look shorter.
  task automatic solve_matrix(input int unsigned n);
    logic [WW:0] cand;
    path_entry_t entry;
    for (int unsigned e = 0; e < MAX_N*MAX_N; e++) via_mem[e] = '0;
    for (int unsigned k = 0; k < n; k++) begin
      for (int unsigned i = 0; i < n; i++) begin
        for (int unsigned j = 0; j < n; j++) begin
          cand = {1'b0, dist_mem[i*n+k]} + {1'b0, dist_mem[k*n+j]};
          if (cand < {1'b0, dist_mem[i*n+j]}) begin
            dist_mem[i*n+j] = cand[WW-1:0];
            via_mem[i*n+j]  = VW'(k + 1);
          end
        end
      end
    end
    for (int unsigned e = 0; e < n*n; e++) begin
      entry.row      = IW'(e / n);
      entry.col      = IW'(e % n);
      entry.path_len = dist_mem[e];
      entry.via      = via_mem[e];
      entry.last     = (e + 1 == n*n);
      due_paths.push_back(entry);
    end
  endtask

  // Store one accepted weight; the last weight of a matrix starts the solve.
  task automatic take_weight(input logic [WW-1:0] w);
    int unsigned n;
    int unsigned slot;
    n    = live_vertices(vertex_count);
    slot = (fill_pos >= n*n) ? 0 : fill_pos;
    dist_mem[slot] = (w > apsp_pkg::NO_EDGE) ? apsp_pkg::NO_EDGE : w;
    fill_pos = slot + 1;
    if (fill_pos == n*n) begin
      fill_pos = 0;
      solve_matrix(n);
    end
  endtask

  // Compare one result word with the oldest outstanding entry.
  task automatic check_result();
    path_entry_t seen;
    path_entry_t want;
    seen = '{row: row_vertex_i, col: col_vertex_i, path_len: distance_i,
             via: via_vertex_i, last: last_of_run_i};
    if (due_paths.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected word row %0d col %0d dist %0d via %0d last %0b",
                 $realtime, seen.row, seen.col, seen.path_len, seen.via, seen.last);
    end else begin
      want = due_paths.pop_front();
      if (seen.row != want.row || seen.col != want.col ||
          seen.path_len != want.path_len || seen.via != want.via ||
          seen.last != want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: exp r%0d c%0d d%0d v%0d l%0b, got r%0d c%0d d%0d v%0d l%0b",
                   $realtime, want.row, want.col, want.path_len, want.via, want.last,
                   seen.row, seen.col, seen.path_len, seen.via, seen.last);
      end
    end
  endtask

  // Track the block at each edge: register writes, accepted weights, results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count = apsp_pkg::VCOUNT_RESET;
      fill_pos     = 0;
      mismatches   = 0;
      due_paths.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        vertex_count = cfg_wdata_i;
        fill_pos     = 0;
      end
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) take_weight(edge_weight_i);
      fail_count_o <= mismatches;
      pending_o    <= due_paths.size();
    end
  end

endmodule

### sim/all_pairs_shortest_path_tb.sv
// Drives weight matrices and vertex counts into the shortest path block, pulls
// its results with a randomly stalling receiver and reports the verdict.
module all_pairs_shortest_path_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned RANDOM_LOAD = 20;
  localparam int unsigned WW          = apsp_pkg::WEIGHT_W;
  localparam int unsigned CW          = apsp_pkg::VCOUNT_W;

  // Four-vertex matrix for the reset count: short chains, missing edges and
  // weights above the no-edge value that must be clipped.
  localparam logic [WW-1:0] DEMO_MATRIX [16] = '{
    20'd0,       20'd5,       apsp_pkg::NO_EDGE, 20'hFFFFF,
    20'd1000000, 20'd0,       20'd7,             20'd1,
    20'd3,       apsp_pkg::NO_EDGE, 20'd0,       20'hFFFFE,
    20'd2,       20'd999998,  20'd1,             20'd0
  };

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [CW-1:0]                  cfg_wdata_i   = '0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_ready_o;
  logic [WW-1:0]                  edge_weight_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i   = 1'b0;
  logic [apsp_pkg::IDX_W-1:0]     row_vertex_o;
  logic [apsp_pkg::IDX_W-1:0]     col_vertex_o;
  logic [WW-1:0]                  distance_o;
  logic [apsp_pkg::VIA_W-1:0]     via_vertex_o;
  logic                           last_of_run_o;

  logic        gaps_on        = 1'b1;
  logic        long_hold_req  = 1'b0;
  logic        long_hold_done = 1'b0;
  int unsigned fail_count;
  int unsigned pending;

  all_pairs_shortest_path dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .edge_weight_i (edge_weight_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .row_vertex_o  (row_vertex_o),
    .col_vertex_o  (col_vertex_o),
    .distance_o    (distance_o),
    .via_vertex_o  (via_vertex_o),
    .last_of_run_o (last_of_run_o)
  );

  apsp_checker path_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .edge_weight_i (edge_weight_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .row_vertex_i  (row_vertex_o),
    .col_vertex_i  (col_vertex_o),
    .distance_i    (distance_o),
    .via_vertex_i  (via_vertex_o),
    .last_of_run_i (last_of_run_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short weights so that relaxations happen, with missing, clipped and
  // full-range weights mixed in.
  function automatic logic [WW-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0:       return apsp_pkg::NO_EDGE;
      1:       return WW'($urandom_range(1000000, 1048575));
      2:       return WW'($urandom);
      default: return WW'($urandom_range(0, 60));
    endcase
  endfunction

  // Mostly small graphs, some larger ones and the zero and oversize counts.
  function automatic logic [CW-1:0] rand_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CW'($urandom_range(9, 15));
      2:       return CW'($urandom_range(5, 8));
      default: return CW'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic int unsigned side_of(input logic [CW-1:0] v);
    if (v == '0) return 1;
    if (v > 8) return 8;
    return 32'(v);
  endfunction

  // Offer one weight word, with an occasional gap before it.
  task automatic push_weight(input logic [WW-1:0] w);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    edge_weight_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_count(input logic [CW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stop offering, wait for every outstanding result, then let the block settle.
  task automatic settle(input int unsigned tail);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // Receiver: random short stalls, plus one long hold-off on request.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        out_ready_i    <= 1'b0;
        long_hold_done <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int unsigned   loaded;
    int unsigned   side;
    int unsigned   loads;
    logic [CW-1:0] pick;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: the reset vertex count, then a load cut short by a register
    // write that also selects the zero count (one vertex, clipped weight).
    foreach (DEMO_MATRIX[e]) push_weight(DEMO_MATRIX[e]);
    settle(20);
    write_count(4'd2);
    repeat (3) push_weight(rand_weight());
    settle(20);
    write_count(4'd0);
    push_weight(20'hFFFFF);
    settle(20);

    // Random phases: mostly small graphs with back-to-back loads and now and
    // then an abandoned load.
    loaded = 0;
    while (loaded < RANDOM_LOAD) begin
      gaps_on <= ($urandom_range(0, 3) != 0);
      pick    = rand_count();
      side    = side_of(pick);
      loads   = (side > 4) ? 1 : $urandom_range(1, 3);
      write_count(pick);
      repeat (loads) begin
        repeat (side * side) push_weight(rand_weight());
        loaded += side * side;
      end
      if (side > 1 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, side * side - 1)) push_weight(rand_weight());
      settle(20);
    end

    // Long receiver hold-off while the sender keeps offering four matrices.
    gaps_on       <= 1'b0;
    long_hold_req <= 1'b1;
    write_count(4'd2);
    repeat (16) push_weight(rand_weight());
    settle(20);

    // Oversize count saturating to eight vertices, with no idling.
    write_count(4'd15);
    repeat (64) push_weight(rand_weight());
    settle(50);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
